@@ design/rcms_pkg.sv @@
// Shared types and constants for the rod cut segment counter.
package rcms_pkg;

    localparam int FieldW = 12;
    localparam int NumSegs = 3;

    typedef struct packed {
        logic              valid;
        logic [FieldW-1:0] count;
    } entry_t;

    localparam int EntryW = $bits(entry_t);

    typedef struct packed {
        logic usable;
        logic fwd_hit;
    } tap_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_INIT,
        ST_FILL,
        ST_DONE
    } state_t;

endpackage

@@ design/rcms_ram.sv @@
// Generic synchronous RAM: one write port, RD_PORTS registered read ports.
module rcms_ram #(
    parameter int WIDTH    = 13,
    parameter int DEPTH    = 4096,
    parameter int RD_PORTS = 2,
    parameter int ADDR_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic [ADDR_W-1:0] rd_addr [RD_PORTS],
    output logic [WIDTH-1:0]  rd_data [RD_PORTS]
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    for (genvar p = 0; p < RD_PORTS; p++)
    begin : g_rd
        always_ff @(posedge clk)
        begin
            rd_data[p] <= mem[rd_addr[p]];
        end
    end

endmodule

@@ design/rcms_relax.sv @@
// Next table entry: best of the three predecessor entries plus one.
module rcms_relax
    import rcms_pkg::*;
(
    input  entry_t ram_entry [NumSegs],
    input  tap_t   tap       [NumSegs],
    input  entry_t fwd_entry,
    output entry_t best
);

    always_comb
    begin
        entry_t             src;
        logic [FieldW-1:0]  cand;
        best = '0;
        for (int k = 0; k < NumSegs; k++)
        begin
            src  = tap[k].fwd_hit ? fwd_entry : ram_entry[k];
            cand = src.count + FieldW'(1);
            if (tap[k].usable && src.valid)
            begin
                if (!best.valid || cand > best.count)
                begin
                    best.valid = 1'b1;
                    best.count = cand;
                end
            end
        end
    end

endmodule

@@ design/rod_cut_max_segments.sv @@
// Top level: rod cut segment counter, table fill sequencer and result register.
//
//   channel | direction | handshake             | payload
//   --------+-----------+-----------------------+--------------------------------------
//   in      | in        | in_valid / in_ready   | rod_length, seg_len_a/b/c (12b each)
//   out     | out       | out_valid / out_ready | max_pieces (12b)
//
// An item with rod length n seeds entry 0 in ST_INIT, fills one table entry per cycle
// for lengths 1..n in ST_FILL and loads the output register from ST_DONE. The next
// transfer can follow in the cycle after the result loads. The rate is set by the single
// table write port, one entry per cycle; two replicated RAMs give the three predecessor
// reads each cycle. Zero or out-of-range rod lengths go straight to ST_DONE with a zero
// result. No clearing pass after reset. A new item is taken while the previous result
// waits; the sequencer holds in its last state until the output register frees.
module rod_cut_max_segments
    import rcms_pkg::*;
#(
    parameter int MAX_LENGTH = 4095
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [FieldW-1:0] rod_length,
    input  logic [FieldW-1:0] seg_len_a,
    input  logic [FieldW-1:0] seg_len_b,
    input  logic [FieldW-1:0] seg_len_c,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [FieldW-1:0] max_pieces
);

    localparam int Depth = MAX_LENGTH + 1;
    localparam int AW    = $clog2(Depth);

    state_t state_reg;
    state_t state_next;

    logic [FieldW-1:0] n_reg;
    logic [FieldW-1:0] seg_reg [NumSegs];
    logic [FieldW-1:0] pos_reg;
    logic [FieldW-1:0] res_reg;
    logic              out_valid_reg;
    logic [FieldW-1:0] max_pieces_reg;

    logic              wr_en;
    logic [AW-1:0]     wr_addr;
    entry_t            wr_data;

    logic              fwd_en_reg;
    logic [AW-1:0]     fwd_addr_reg;
    entry_t            fwd_data_reg;

    logic [FieldW:0]   rd_base;
    logic [AW-1:0]     rd_addr      [NumSegs];
    logic              rd_usable    [NumSegs];
    logic [AW-1:0]     rd_addr_reg  [NumSegs];
    logic              rd_usable_reg[NumSegs];

    logic [AW-1:0]     ram0_addr [2];
    logic [EntryW-1:0] ram0_data [2];
    logic [AW-1:0]     ram1_addr [1];
    logic [EntryW-1:0] ram1_data [1];

    entry_t            ram_entry [NumSegs];
    tap_t              tap       [NumSegs];
    entry_t            best;

    logic              in_xfer;
    logic              too_long;
    logic              out_free;

    assign in_ready = (state_reg == ST_IDLE);
    assign in_xfer  = in_valid && in_ready;
    assign too_long = (32'(rod_length) > 32'(MAX_LENGTH));
    assign out_free = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer)
                begin
                    state_next = (too_long || rod_length == '0) ? ST_DONE : ST_INIT;
                end
            end
            ST_INIT:
            begin
                state_next = ST_FILL;
            end
            ST_FILL:
            begin
                if (pos_reg == n_reg)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = '0;
        wr_data = '0;
        unique case (state_reg)
            ST_INIT:
            begin
                wr_en         = 1'b1;
                wr_data.valid = 1'b1;
            end
            ST_FILL:
            begin
                wr_en   = 1'b1;
                wr_addr = AW'(pos_reg);
                wr_data = best;
            end
            ST_IDLE, ST_DONE:
            begin
                wr_en = 1'b0;
            end
            default:
            begin
                wr_en = 1'b0;
            end
        endcase
    end

    assign rd_base = {1'b0, pos_reg} + (FieldW + 1)'(1);

    always_comb
    begin
        for (int k = 0; k < NumSegs; k++)
        begin
            rd_usable[k] = (seg_reg[k] != '0) && ({1'b0, seg_reg[k]} <= rd_base);
            rd_addr[k]   = rd_usable[k] ? AW'(rd_base - {1'b0, seg_reg[k]}) : '0;
        end
    end

    assign ram0_addr[0] = rd_addr[0];
    assign ram0_addr[1] = rd_addr[1];
    assign ram1_addr[0] = rd_addr[2];

    rcms_ram #(
        .WIDTH    (EntryW),
        .DEPTH    (Depth),
        .RD_PORTS (2),
        .ADDR_W   (AW)
    ) u_ram0 (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (ram0_addr),
        .rd_data (ram0_data)
    );

    rcms_ram #(
        .WIDTH    (EntryW),
        .DEPTH    (Depth),
        .RD_PORTS (1),
        .ADDR_W   (AW)
    ) u_ram1 (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (ram1_addr),
        .rd_data (ram1_data)
    );

    assign ram_entry[0] = ram0_data[0];
    assign ram_entry[1] = ram0_data[1];
    assign ram_entry[2] = ram1_data[0];

    always_comb
    begin
        for (int k = 0; k < NumSegs; k++)
        begin
            tap[k].usable  = rd_usable_reg[k];
            tap[k].fwd_hit = fwd_en_reg && (fwd_addr_reg == rd_addr_reg[k]);
        end
    end

    rcms_relax u_relax (
        .ram_entry (ram_entry),
        .tap       (tap),
        .fwd_entry (fwd_data_reg),
        .best      (best)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            fwd_en_reg    <= 1'b0;
            pos_reg       <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            fwd_en_reg <= wr_en;
            if (state_reg == ST_DONE && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (in_xfer)
            begin
                pos_reg <= '0;
            end
            else if (state_reg == ST_INIT || state_reg == ST_FILL)
            begin
                pos_reg <= pos_reg + FieldW'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        fwd_addr_reg <= wr_addr;
        fwd_data_reg <= wr_data;
        for (int k = 0; k < NumSegs; k++)
        begin
            rd_addr_reg[k]   <= rd_addr[k];
            rd_usable_reg[k] <= rd_usable[k];
        end
        if (in_xfer)
        begin
            n_reg      <= rod_length;
            seg_reg[0] <= seg_len_a;
            seg_reg[1] <= seg_len_b;
            seg_reg[2] <= seg_len_c;
            res_reg    <= '0;
        end
        else if (state_reg == ST_FILL && pos_reg == n_reg)
        begin
            res_reg <= best.valid ? best.count : '0;
        end
        if (state_reg == ST_DONE && out_free)
        begin
            max_pieces_reg <= res_reg;
        end
    end

    assign out_valid  = out_valid_reg;
    assign max_pieces = max_pieces_reg;

`ifndef SYNTHESIS
    a_fill_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_FILL |-> pos_reg != '0 && pos_reg <= n_reg)
        else $error("fill position outside 1..n");

    a_init_to_fill: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_INIT |=> state_reg == ST_FILL && pos_reg == FieldW'(1))
        else $error("seed cycle not followed by fill of length 1");

    a_long_rod_zero: assert property (@(posedge clk) disable iff (!rst_n)
        in_xfer && too_long |=> state_reg == ST_DONE && res_reg == '0)
        else $error("out-of-range rod did not yield zero");

    a_wr_in_table: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> 32'(wr_addr) <= 32'(MAX_LENGTH))
        else $error("table write beyond last entry");
`endif

endmodule

@@ verif/tb_rod_cut_max_segments.sv @@
// Self-checking testbench for the rod cut segment counter: directed and random queries against a DP predictor.
module tb_rod_cut_max_segments
    import rcms_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int MaxLen = 4095;
    localparam int NumRandom = 122;

    typedef struct {
        logic [FieldW-1:0] rod;
        logic [FieldW-1:0] seg_a;
        logic [FieldW-1:0] seg_b;
        logic [FieldW-1:0] seg_c;
        bit                calm;
    } cut_query_t;

    typedef struct {
        cut_query_t        query;
        logic [FieldW-1:0] pieces;
    } cut_answer_t;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              in_valid = 1'b0;
    logic              in_ready;
    logic [FieldW-1:0] rod_length = '0;
    logic [FieldW-1:0] seg_len_a = '0;
    logic [FieldW-1:0] seg_len_b = '0;
    logic [FieldW-1:0] seg_len_c = '0;
    logic              out_valid;
    logic              out_ready = 1'b0;
    logic [FieldW-1:0] max_pieces;

    cut_query_t  pending_queries[$];
    cut_answer_t expected_pieces[$];
    cut_query_t  held_query;

    int mismatches = 0;
    int queries_sent = 0;
    int results_seen = 0;
    int no_cut_seen = 0;
    int full_length_sent = 0;
    int top_count_seen = 0;
    int in_gap = 0;
    int out_stall = 0;

    rod_cut_max_segments #(
        .MAX_LENGTH(MaxLen)
    ) i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .rod_length(rod_length),
        .seg_len_a (seg_len_a),
        .seg_len_b (seg_len_b),
        .seg_len_c (seg_len_c),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .max_pieces(max_pieces)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    function automatic logic [FieldW-1:0] count_max_pieces(cut_query_t q);
        bit reach[0:MaxLen];
        int best[0:MaxLen];
        int segs[3];
        int n;
        int cand;
        n = int'(q.rod);
        segs[0] = int'(q.seg_a);
        segs[1] = int'(q.seg_b);
        segs[2] = int'(q.seg_c);
        if (n > MaxLen)
        begin
            return '0;
        end
        reach[0] = 1'b1;
        best[0] = 0;
        for (int i = 1; i <= n; i++)
        begin
            reach[i] = 1'b0;
            best[i] = 0;
            for (int s = 0; s < 3; s++)
            begin
                if (segs[s] != 0 && segs[s] <= i && reach[i - segs[s]])
                begin
                    cand = best[i - segs[s]] + 1;
                    if (!reach[i] || cand > best[i])
                    begin
                        reach[i] = 1'b1;
                        best[i] = cand;
                    end
                end
            end
        end
        return reach[n] ? best[n][FieldW-1:0] : '0;
    endfunction

    task automatic report_mismatch(string msg);
        $display("MISMATCH at %0t: %s", $realtime, msg);
        mismatches++;
    endtask

    function automatic cut_query_t make_query(int rod, int a, int b, int c, bit calm);
        cut_query_t q;
        q.rod = rod[FieldW-1:0];
        q.seg_a = a[FieldW-1:0];
        q.seg_b = b[FieldW-1:0];
        q.seg_c = c[FieldW-1:0];
        q.calm = calm;
        return q;
    endfunction

    function automatic int pick_segment();
        int mode;
        mode = $urandom_range(0, 9);
        if (mode == 0)
        begin
            return 0;
        end
        else if (mode <= 6)
        begin
            return $urandom_range(1, 24);
        end
        else if (mode <= 8)
        begin
            return $urandom_range(1, 300);
        end
        return $urandom_range(0, MaxLen);
    endfunction

    function automatic int pick_rod();
        int mode;
        mode = $urandom_range(0, 19);
        if (mode == 0)
        begin
            return $urandom_range(0, MaxLen);
        end
        else if (mode == 1)
        begin
            return $urandom_range(256, 1023);
        end
        return $urandom_range(0, 255);
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            in_gap = 0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                expected_pieces.push_back('{held_query, count_max_pieces(held_query)});
                queries_sent++;
                if (held_query.rod == MaxLen[FieldW-1:0])
                begin
                    full_length_sent++;
                end
            end
            if (!in_valid || in_ready)
            begin
                if (in_gap != 0)
                begin
                    in_gap--;
                    in_valid <= 1'b0;
                end
                else if (pending_queries.size() != 0)
                begin
                    held_query = pending_queries.pop_front();
                    rod_length <= held_query.rod;
                    seg_len_a <= held_query.seg_a;
                    seg_len_b <= held_query.seg_b;
                    seg_len_c <= held_query.seg_c;
                    in_valid <= 1'b1;
                    in_gap = held_query.calm ? 0 : $urandom_range(0, 6);
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        cut_answer_t exp_ans;
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            out_stall = 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                results_seen++;
                if (expected_pieces.size() == 0)
                begin
                    report_mismatch($sformatf("unexpected result max_pieces=%0d", max_pieces));
                end
                else
                begin
                    exp_ans = expected_pieces.pop_front();
                    if (max_pieces !== exp_ans.pieces)
                    begin
                        report_mismatch($sformatf(
                            "rod=%0d segs=%0d/%0d/%0d max_pieces got %0d want %0d",
                            exp_ans.query.rod, exp_ans.query.seg_a, exp_ans.query.seg_b,
                            exp_ans.query.seg_c, max_pieces, exp_ans.pieces));
                    end
                    if (exp_ans.pieces == '0)
                    begin
                        no_cut_seen++;
                    end
                    if (int'(exp_ans.pieces) > top_count_seen)
                    begin
                        top_count_seen = int'(exp_ans.pieces);
                    end
                end
                if (expected_pieces.size() != 0 && expected_pieces[0].query.calm)
                begin
                    out_stall = 0;
                end
                else
                begin
                    out_stall = $urandom_range(0, 6);
                end
            end
            if (out_stall != 0)
            begin
                if (out_valid)
                begin
                    out_stall--;
                end
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= 1'b1;
            end
        end
    end

    initial
    begin
        int rod;
        bit calm;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        pending_queries.push_back(make_query(0, 1, 2, 3, 0));
        pending_queries.push_back(make_query(0, MaxLen, MaxLen, MaxLen, 0));
        pending_queries.push_back(make_query(0, 0, 0, 0, 0));
        pending_queries.push_back(make_query(MaxLen, 1, 1, 1, 0));
        pending_queries.push_back(make_query(MaxLen, MaxLen, MaxLen, MaxLen, 0));
        pending_queries.push_back(make_query(MaxLen, MaxLen, 2, 3, 0));
        pending_queries.push_back(make_query(MaxLen, 2, 4094, 4093, 0));
        pending_queries.push_back(make_query(4094, 2047, 1, MaxLen, 0));
        pending_queries.push_back(make_query(2048, 2048, 1024, MaxLen, 0));
        pending_queries.push_back(make_query(7, 2, 2, 2, 0));
        pending_queries.push_back(make_query(7, 0, 0, 0, 0));
        pending_queries.push_back(make_query(10, 0, 3, 0, 0));
        pending_queries.push_back(make_query(12, 5, 0, 4, 0));
        pending_queries.push_back(make_query(5, 7, 8, 9, 0));
        pending_queries.push_back(make_query(1, 1, MaxLen, MaxLen, 0));
        pending_queries.push_back(make_query(13, 5, 3, 2, 0));
        pending_queries.push_back(make_query(23, 11, 7, 5, 0));
        pending_queries.push_back(make_query(1365, 1365, 2730, 1, 0));

        for (int k = 0; k < NumRandom; k++)
        begin
            calm = ((k / 20) % 3) == 1;
            rod = pick_rod();
            pending_queries.push_back(make_query(rod, pick_segment(), pick_segment(),
                                                 pick_segment(), calm));
        end

        while (pending_queries.size() != 0 || in_valid)
        begin
            @(posedge clk);
        end
        while (expected_pieces.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (MaxLen + 20) @(posedge clk);

        $display("Covered %0d rod cut queries (%0d at full length), %0d results checked",
                 queries_sent, full_length_sent, results_seen);
        $display("%0d queries had no exact cut; largest piece count seen %0d",
                 no_cut_seen, top_count_seen);
        if (mismatches == 0)
        begin
            $display("Regression PASS");
        end
        else
        begin
            $display("Regression FAIL");
        end
        $finish;
    end

    initial
    begin
        #20_000_000;
        $display("Timeout with %0d results outstanding", expected_pieces.size());
        $display("Regression FAIL");
        $finish;
    end

endmodule
